>>> rtl/bpfa_pkg.sv
// shared types, constants and helpers for the bitmap page frame allocator
`timescale 1ns / 1ps
package bpfa_pkg;

    localparam int NUM_FRAMES_DEF      = 4096;
    localparam int PAGE_BYTES_DEF      = 4096;
    localparam int WORD_BITS_DEF       = 32;

    localparam int LOW_RESERVED_LAST   = 512;
    localparam int HIGH_RESERVED_FIRST = 3840;
    localparam int HIGH_RESERVED_LAST  = 4095;

    localparam logic [1:0] KIND_ALLOC_ONE = 2'd0;
    localparam logic [1:0] KIND_ALLOC_RUN = 2'd1;
    localparam logic [1:0] KIND_FREE      = 2'd2;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NO_SPACE     = 3'd1,
        ST_ZERO_COUNT   = 3'd2,
        ST_MISALIGNED   = 3'd3,
        ST_OUT_OF_RANGE = 3'd4,
        ST_DOUBLE_FREE  = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN_INIT,
        OP_WORD_SKIP,
        OP_WORD_FOUND,
        OP_BIT_INIT,
        OP_BIT_STEP,
        OP_BIT_NEXT,
        OP_BIT_FOUND,
        OP_MARK,
        OP_MARK_LAST,
        OP_FREE_INIT,
        OP_FREE_CLEAR,
        OP_REJECT,
        OP_PUBLISH
    } op_t;

    typedef struct packed {
        op_t     op;
        status_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       len_zero;
        logic       misaligned;
        logic       out_of_range;
        logic       all_free;
        logic       all_used;
        logic       fits_word;
        logic       bit_fits;
        logic       last_bit;
        logic       last_word;
        logic       mark_last;
        logic       target_clear;
    } dp_stat_t;

    function automatic int reset_count(input int num);
        int lo;
        int hi;
        lo = (num < LOW_RESERVED_LAST + 1) ? num : LOW_RESERVED_LAST + 1;
        hi = 0;
        if (num > HIGH_RESERVED_FIRST)
        begin
            hi = ((num < HIGH_RESERVED_LAST + 1) ? num : HIGH_RESERVED_LAST + 1)
                 - HIGH_RESERVED_FIRST;
        end
        return lo + hi;
    endfunction

endpackage

>>> rtl/bitmap_page_frame_allocator_core.sv
// top level of the first-fit bitmap page frame allocator
`timescale 1ns / 1ps
// request channel: kind, run_length, free_address with in_valid / in_stall.
// result channel: page_address, status, frames_used with out_valid / out_stall.
// one result item per request item, in order. one request at a time:
// in_stall is high from acceptance until the result has been loaded into
// the output register.
// a rejected request goes straight to the result; a free reads the word
// that holds its frame, checks the bit and clears it. an allocation steps
// over wholly free or wholly used words whole, scans mixed words bit by bit,
// then marks the run word by word; single-port bitmap reads are registered.
// reset: bitmap words read as their reset pattern (low reserved frames and
// top reserved frames used) until first written, used count loaded at once;
// no clearing pass, requests are taken from the first cycle after reset.
// a stalled result holds in the output register; the next request may be
// accepted and worked on meanwhile, and its result waits until the
// output register has been taken.
module bitmap_page_frame_allocator_core
    import bpfa_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int PAGE_BYTES = PAGE_BYTES_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [12:0] run_length,
    input  logic [31:0] free_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [23:0] page_address,
    output logic [2:0]  status,
    output logic [12:0] frames_used
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bpfa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    bpfa_datapath #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_BYTES (PAGE_BYTES),
        .WORD_BITS  (WORD_BITS)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .kind         (kind),
        .run_length   (run_length),
        .free_address (free_address),
        .cmd          (cmd),
        .stat         (stat),
        .page_address (page_address),
        .status       (status),
        .frames_used  (frames_used)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted without going busy");

    a_fail_zero_address: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> page_address == 24'd0)
        else $error("failed request returned an address");

    a_publish_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a request in progress");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(frames_used))
        else $error("stalled result changed");

endmodule

>>> rtl/bpfa_ctrl.sv
// controller state machine sequencing scan, mark and free
`timescale 1ns / 1ps
module bpfa_ctrl
    import bpfa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_DISPATCH = 10'b0000000010,
        S_SWAIT    = 10'b0000000100,
        S_SEVAL    = 10'b0000001000,
        S_SBIT     = 10'b0000010000,
        S_MWAIT    = 10'b0000100000,
        S_MWRITE   = 10'b0001000000,
        S_FWAIT    = 10'b0010000000,
        S_FCHECK   = 10'b0100000000,
        S_DONE     = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = OP_NONE;
        cmd.code       = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.kind == KIND_ALLOC_ONE || stat.kind == KIND_ALLOC_RUN)
                begin
                    if (stat.len_zero)
                    begin
                        cmd.op     = OP_REJECT;
                        cmd.code   = ST_ZERO_COUNT;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.op     = OP_SCAN_INIT;
                        state_next = S_SWAIT;
                    end
                end
                else if (stat.kind == KIND_FREE)
                begin
                    if (stat.misaligned)
                    begin
                        cmd.op     = OP_REJECT;
                        cmd.code   = ST_MISALIGNED;
                        state_next = S_DONE;
                    end
                    else if (stat.out_of_range)
                    begin
                        cmd.op     = OP_REJECT;
                        cmd.code   = ST_OUT_OF_RANGE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.op     = OP_FREE_INIT;
                        state_next = S_FWAIT;
                    end
                end
                else
                begin
                    cmd.op     = OP_REJECT;
                    cmd.code   = ST_OK;
                    state_next = S_DONE;
                end
            end
            S_SWAIT:
            begin
                state_next = S_SEVAL;
            end
            S_SEVAL:
            begin
                if (stat.fits_word)
                begin
                    cmd.op     = OP_WORD_FOUND;
                    state_next = S_MWAIT;
                end
                else if (stat.all_free || stat.all_used)
                begin
                    if (stat.last_word)
                    begin
                        cmd.op     = OP_REJECT;
                        cmd.code   = ST_NO_SPACE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.op     = OP_WORD_SKIP;
                        state_next = S_SWAIT;
                    end
                end
                else
                begin
                    cmd.op     = OP_BIT_INIT;
                    state_next = S_SBIT;
                end
            end
            S_SBIT:
            begin
                if (stat.bit_fits)
                begin
                    cmd.op     = OP_BIT_FOUND;
                    state_next = S_MWAIT;
                end
                else if (stat.last_bit)
                begin
                    if (stat.last_word)
                    begin
                        cmd.op     = OP_REJECT;
                        cmd.code   = ST_NO_SPACE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.op     = OP_BIT_NEXT;
                        state_next = S_SWAIT;
                    end
                end
                else
                begin
                    cmd.op = OP_BIT_STEP;
                end
            end
            S_MWAIT:
            begin
                state_next = S_MWRITE;
            end
            S_MWRITE:
            begin
                if (stat.mark_last)
                begin
                    cmd.op     = OP_MARK_LAST;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_MARK;
                    state_next = S_MWAIT;
                end
            end
            S_FWAIT:
            begin
                state_next = S_FCHECK;
            end
            S_FCHECK:
            begin
                if (stat.target_clear)
                begin
                    cmd.op   = OP_REJECT;
                    cmd.code = ST_DOUBLE_FREE;
                end
                else
                begin
                    cmd.op = OP_FREE_CLEAR;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = OP_PUBLISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/bpfa_datapath.sv
// frame bitmap memory, scan registers, used count and result registers
`timescale 1ns / 1ps
module bpfa_datapath
    import bpfa_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int PAGE_BYTES = PAGE_BYTES_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  kind,
    input  logic [12:0] run_length,
    input  logic [31:0] free_address,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    output logic [23:0] page_address,
    output logic [2:0]  status,
    output logic [12:0] frames_used
);

    localparam int MAP_WORDS   = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WLOG        = $clog2(WORD_BITS);
    localparam int PLOG        = $clog2(PAGE_BYTES);
    localparam int FXW         = WIDX + WLOG;
    localparam int CW          = $clog2(NUM_FRAMES + 1);
    localparam int RW          = CW + 1;
    localparam int CMPW        = ((RW > 13) ? RW : 13) + 1;
    localparam int LSW         = ((FXW > 13) ? FXW : 13) + 1;
    localparam int COUNT_RESET = reset_count(NUM_FRAMES);

    function automatic logic [WORD_BITS-1:0] reset_word(input logic [WIDX-1:0] idx);
        logic [WORD_BITS-1:0] w;
        int                   f;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            f    = int'(idx) * WORD_BITS + b;
            w[b] = (f <= LOW_RESERVED_LAST)
                   || (f >= HIGH_RESERVED_FIRST && f <= HIGH_RESERVED_LAST);
        end
        return w;
    endfunction

    function automatic logic [WORD_BITS-1:0] slack_word(input logic [WIDX-1:0] idx);
        logic [WORD_BITS-1:0] w;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            w[b] = (int'(idx) * WORD_BITS + b) >= NUM_FRAMES;
        end
        return w;
    endfunction

    logic [WORD_BITS-1:0] mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] valid_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_init_reg;

    logic [1:0]      kind_reg, kind_next;
    logic [12:0]     len_reg, len_next;
    logic [31:0]     addr_reg, addr_next;
    logic [WIDX-1:0] wptr_reg, wptr_next;
    logic [WLOG-1:0] bptr_reg, bptr_next;
    logic [RW-1:0]   run_reg, run_next;
    logic [FXW-1:0]  first_reg, first_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [23:0]     page_res_reg, page_res_next;
    status_t         status_res_reg, status_res_next;
    logic [23:0]     page_out_reg, page_out_next;
    status_t         status_out_reg, status_out_next;
    logic [12:0]     used_out_reg, used_out_next;

    logic [WORD_BITS-1:0] word_eff;
    logic [WORD_BITS-1:0] mark_mask;
    logic [WORD_BITS-1:0] wr_data;
    logic                 wr_en;
    logic [FXW-1:0]       base;
    logic [FXW-1:0]       bit_frame;
    logic [LSW-1:0]       last_full;
    logic [FXW-1:0]       last_frame;
    logic [31:0]          free_frame;
    logic [WIDX-1:0]      free_word;
    logic [WLOG-1:0]      free_bit;
    logic [FXW+PLOG-1:0]  page_full;
    logic                 bit_used;

    assign word_eff   = (rd_init_reg ? reset_word(wptr_reg) : rd_data_reg)
                        | slack_word(wptr_reg);
    assign base       = {wptr_reg, {WLOG{1'b0}}};
    assign bit_frame  = base + FXW'(bptr_reg);
    assign bit_used   = word_eff[bptr_reg];
    assign last_full  = LSW'(first_reg) + LSW'(len_reg) - LSW'(1);
    assign last_frame = FXW'(last_full);
    assign free_frame = addr_reg >> PLOG;
    assign free_word  = WIDX'(free_frame >> WLOG);
    assign free_bit   = free_frame[WLOG-1:0];
    assign page_full  = {first_reg, {PLOG{1'b0}}};

    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            mark_mask[b] = ((base + FXW'(b)) >= first_reg) && ((base + FXW'(b)) <= last_frame);
        end
    end

    always_comb
    begin
        stat.kind         = kind_reg;
        stat.len_zero     = (len_reg == 13'd0);
        stat.misaligned   = (addr_reg[PLOG-1:0] != '0);
        stat.out_of_range = (free_frame >= 32'(NUM_FRAMES));
        stat.all_free     = (word_eff == '0);
        stat.all_used     = (&word_eff);
        stat.fits_word    = (word_eff == '0)
                            && (CMPW'(run_reg) + CMPW'(WORD_BITS) >= CMPW'(len_reg));
        stat.bit_fits     = !bit_used && (CMPW'(run_reg) + CMPW'(1) == CMPW'(len_reg));
        stat.last_bit     = (bptr_reg == WLOG'(WORD_BITS - 1));
        stat.last_word    = (wptr_reg == WIDX'(MAP_WORDS - 1));
        stat.mark_last    = (wptr_reg == last_frame[FXW-1:WLOG]);
        stat.target_clear = !word_eff[free_bit];
    end

    always_comb
    begin
        kind_next       = kind_reg;
        len_next        = len_reg;
        addr_next       = addr_reg;
        wptr_next       = wptr_reg;
        bptr_next       = bptr_reg;
        run_next        = run_reg;
        first_next      = first_reg;
        count_next      = count_reg;
        page_res_next   = page_res_reg;
        status_res_next = status_res_reg;
        page_out_next   = page_out_reg;
        status_out_next = status_out_reg;
        used_out_next   = used_out_reg;
        wr_en           = 1'b0;
        wr_data         = word_eff | mark_mask;
        case (cmd.op)
            OP_LOAD:
            begin
                kind_next = kind;
                len_next  = (kind == KIND_ALLOC_ONE) ? 13'd1 : run_length;
                addr_next = free_address;
            end
            OP_SCAN_INIT:
            begin
                wptr_next = '0;
                run_next  = '0;
            end
            OP_WORD_SKIP:
            begin
                if (word_eff == '0)
                begin
                    if (run_reg == '0)
                    begin
                        first_next = base;
                    end
                    run_next = run_reg + RW'(WORD_BITS);
                end
                else
                begin
                    run_next = '0;
                end
                wptr_next = wptr_reg + WIDX'(1);
            end
            OP_WORD_FOUND:
            begin
                first_next = (run_reg == '0) ? base : first_reg;
                wptr_next  = first_next[FXW-1:WLOG];
            end
            OP_BIT_INIT:
            begin
                bptr_next = '0;
            end
            OP_BIT_STEP, OP_BIT_NEXT:
            begin
                if (bit_used)
                begin
                    run_next = '0;
                end
                else
                begin
                    if (run_reg == '0)
                    begin
                        first_next = bit_frame;
                    end
                    run_next = run_reg + RW'(1);
                end
                if (cmd.op == OP_BIT_STEP)
                begin
                    bptr_next = bptr_reg + WLOG'(1);
                end
                else
                begin
                    wptr_next = wptr_reg + WIDX'(1);
                end
            end
            OP_BIT_FOUND:
            begin
                first_next = (run_reg == '0) ? bit_frame : first_reg;
                wptr_next  = first_next[FXW-1:WLOG];
            end
            OP_MARK:
            begin
                wr_en     = 1'b1;
                wptr_next = wptr_reg + WIDX'(1);
            end
            OP_MARK_LAST:
            begin
                wr_en           = 1'b1;
                count_next      = count_reg + CW'(len_reg);
                page_res_next   = 24'(page_full);
                status_res_next = ST_OK;
            end
            OP_FREE_INIT:
            begin
                wptr_next = free_word;
            end
            OP_FREE_CLEAR:
            begin
                wr_en           = 1'b1;
                wr_data         = word_eff & ~(WORD_BITS'(1) << free_bit);
                count_next      = count_reg - CW'(1);
                page_res_next   = '0;
                status_res_next = ST_OK;
            end
            OP_REJECT:
            begin
                page_res_next   = '0;
                status_res_next = cmd.code;
            end
            OP_PUBLISH:
            begin
                page_out_next   = page_res_reg;
                status_out_next = status_res_reg;
                used_out_next   = 13'(count_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wptr_reg] <= wr_data;
        end
        rd_data_reg <= mem[wptr_reg];
        rd_init_reg <= !valid_reg[wptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= CW'(COUNT_RESET);
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wptr_reg] <= 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        len_reg        <= len_next;
        addr_reg       <= addr_next;
        wptr_reg       <= wptr_next;
        bptr_reg       <= bptr_next;
        run_reg        <= run_next;
        first_reg      <= first_next;
        page_res_reg   <= page_res_next;
        status_res_reg <= status_res_next;
        page_out_reg   <= page_out_next;
        status_out_reg <= status_out_next;
        used_out_reg   <= used_out_next;
    end

    assign page_address = page_out_reg;
    assign status       = status_out_reg;
    assign frames_used  = used_out_reg;

endmodule
